// ===== src/smx_pkg.sv =====
// Shared opcodes, status codes, types and defaults of the stack machine execute unit.
`default_nettype none
package smx_pkg;

  localparam int STACK_DEPTH_DEF  = 1024;
  localparam int GLOBAL_DEPTH_DEF = 256;
  localparam logic [8:0] GIU_RESET = 9'd256;

  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_PUSHC = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_SUB   = 8'd3;
  localparam logic [7:0] OP_MUL   = 8'd4;
  localparam logic [7:0] OP_DIV   = 8'd5;
  localparam logic [7:0] OP_MOD   = 8'd6;
  localparam logic [7:0] OP_RDINT = 8'd7;
  localparam logic [7:0] OP_WRINT = 8'd8;
  localparam logic [7:0] OP_RDCHR = 8'd9;
  localparam logic [7:0] OP_WRCHR = 8'd10;
  localparam logic [7:0] OP_PUSHG = 8'd11;
  localparam logic [7:0] OP_POPG  = 8'd12;
  localparam logic [7:0] OP_ASF   = 8'd13;
  localparam logic [7:0] OP_RSF   = 8'd14;
  localparam logic [7:0] OP_PUSHL = 8'd15;
  localparam logic [7:0] OP_POPL  = 8'd16;
  localparam logic [7:0] OP_EQ    = 8'd17;
  localparam logic [7:0] OP_NE    = 8'd18;
  localparam logic [7:0] OP_LT    = 8'd19;
  localparam logic [7:0] OP_LE    = 8'd20;
  localparam logic [7:0] OP_GT    = 8'd21;
  localparam logic [7:0] OP_GE    = 8'd22;
  localparam logic [7:0] OP_JMP   = 8'd23;
  localparam logic [7:0] OP_BRF   = 8'd24;
  localparam logic [7:0] OP_BRT   = 8'd25;
  localparam logic [7:0] OP_CALL  = 8'd26;
  localparam logic [7:0] OP_RET   = 8'd27;
  localparam logic [7:0] OP_DROP  = 8'd28;
  localparam logic [7:0] OP_PUSHR = 8'd29;
  localparam logic [7:0] OP_POPR  = 8'd30;
  localparam logic [7:0] OP_DUP   = 8'd31;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HALTED = 3'd1;
  localparam logic [2:0] ST_DIVZ   = 3'd2;
  localparam logic [2:0] ST_STACK  = 3'd3;
  localparam logic [2:0] ST_GLOBAL = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_CHR  = 2'd2;

  typedef struct packed {
    logic       start;
    logic [7:0] op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

// ===== src/smx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/smx_alu.sv =====
// Shared arithmetic and compare unit: registered add, sub, mul, compare; bit-serial divide.
`default_nettype none
module smx_alu (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire smx_pkg::alu_req_t req,
  input  wire logic [31:0]     a,
  input  wire logic [31:0]     b,
  output smx_pkg::alu_rsp_t    rsp
);
  import smx_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        negq_r, negq_nxt;
  logic        negr_r, negr_nxt;
  logic        mod_r, mod_nxt;
  logic [31:0] res_r, res_nxt;
  logic [32:0] rem_sh;
  logic [31:0] prod;

  assign prod = a * b;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    mod_nxt  = mod_r;
    res_nxt  = res_r;
    rem_sh   = {rem_r[31:0], quo_r[31]};
    if (busy_r) begin
      if (cnt_r != 6'd0) begin
        quo_nxt = {quo_r[30:0], 1'b0};
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_nxt    = rem_sh - {1'b0, dvs_r};
          quo_nxt[0] = 1'b1;
        end else begin
          rem_nxt = rem_sh;
        end
        cnt_nxt = cnt_r - 6'd1;
      end else begin
        if (mod_r) begin
          res_nxt = negr_r ? (32'd0 - rem_r[31:0]) : rem_r[31:0];
        end else begin
          res_nxt = negq_r ? (32'd0 - quo_r) : quo_r;
        end
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      if (req.op == OP_DIV || req.op == OP_MOD) begin
        busy_nxt = 1'b1;
        cnt_nxt  = 6'd32;
        rem_nxt  = 33'd0;
        quo_nxt  = a[31] ? (32'd0 - a) : a;
        dvs_nxt  = b[31] ? (32'd0 - b) : b;
        negq_nxt = a[31] ^ b[31];
        negr_nxt = a[31];
        mod_nxt  = (req.op == OP_MOD);
      end else begin
        done_nxt = 1'b1;
        unique case (req.op)
          OP_ADD:  res_nxt = a + b;
          OP_SUB:  res_nxt = a - b;
          OP_MUL:  res_nxt = prod;
          OP_EQ:   res_nxt = {31'd0, a == b};
          OP_NE:   res_nxt = {31'd0, a != b};
          OP_LT:   res_nxt = {31'd0, $signed(a) < $signed(b)};
          OP_LE:   res_nxt = {31'd0, $signed(a) <= $signed(b)};
          OP_GT:   res_nxt = {31'd0, $signed(a) > $signed(b)};
          OP_GE:   res_nxt = {31'd0, $signed(a) >= $signed(b)};
          default: res_nxt = 32'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
    mod_r  <= mod_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;
endmodule
`default_nettype wire

// ===== src/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit: sequencer, stack and global RAMs, state.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: instr_word, read_value
//  out_    | out | out_tvalid/tready  | tdata: next_pc, out_value, status; tuser: kind
//  cfg_    | in  | cfg_we             | cfg_wdata: globals_in_use
//
// A request walks decode, two stack reads, an optional ALU phase and write back.
// Add, sub, mul, compare, div and mod take the ALU phase; div and mod stay in it while
// the shared ALU divides one quotient bit per cycle.
// Reset is synchronous and active low; stack and global RAMs are not cleared.
// in_tready is high only in the idle state. A held output result stalls write back
// until out_tready takes the previous one.
`default_nettype none
module stack_machine_execute_unit #(
  parameter int STACK_DEPTH  = smx_pkg::STACK_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = smx_pkg::GLOBAL_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] instr_word, [63:32] read_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // [23:0] next_pc, [55:24] out_value,
                                       // [58:56] status, [63:59] zero
  output logic      [1:0]  out_tuser,  // [1:0] out_kind
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata   // [8:0] globals_in_use
);
  import smx_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int GAW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
  localparam int SW  = ((SPW > 24) ? SPW : 24) + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_ALU  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  logic [2:0]     state_r, state_nxt;
  logic [31:0]    instr_r, rv_r;
  logic [31:0]    a_r, b_r, g_r, res_r;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [SPW-1:0] fp_r, fp_nxt;
  logic [23:0]    pc_r, pc_nxt;
  logic [31:0]    retv_r, retv_nxt;
  logic           halted_r, halted_nxt;
  logic [8:0]     giu_r;
  logic           out_valid_r;
  logic [63:0]    out_data_r;
  logic [1:0]     out_user_r;

  logic [7:0]     op;
  logic           is_alu;
  logic           wb_go;
  logic [31:0]    st_rdata, g_rdata;
  logic [SAW-1:0] st_raddr, st_waddr;
  logic           st_we, g_we;
  logic [31:0]    st_wdata;
  logic [2:0]     status;
  logic [23:0]    npc;
  logic [1:0]     kind;
  logic [31:0]    val;

  logic signed [SW-1:0] imm_s, sp_s, fp_s, d_s, idx_s, giu_s, gd_s, asf_top;
  logic [SPW-1:0] sp_m1, sp_m2, sp_p1, fp_m1;
  logic [SPW-1:0] idx_u;
  logic [31:0]    imm32;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  assign op      = instr_r[31:24];
  assign imm32   = {{8{instr_r[23]}}, instr_r[23:0]};
  assign imm_s   = $signed({{(SW-24){instr_r[23]}}, instr_r[23:0]});
  assign sp_s    = $signed({{(SW-SPW){1'b0}}, sp_r});
  assign fp_s    = $signed({{(SW-SPW){1'b0}}, fp_r});
  assign d_s     = SW'(STACK_DEPTH);
  assign gd_s    = SW'(GLOBAL_DEPTH);
  assign giu_s   = $signed({{(SW-9){1'b0}}, giu_r});
  assign idx_s   = fp_s + imm_s;
  assign idx_u   = idx_s[SPW-1:0];
  assign asf_top = sp_s + SW'(1) + imm_s;
  assign sp_m1   = sp_r - SPW'(1);
  assign sp_m2   = sp_r - SPW'(2);
  assign sp_p1   = sp_r + SPW'(1);
  assign fp_m1   = fp_r - SPW'(1);

  assign is_alu = (op >= OP_ADD && op <= OP_MOD) || (op >= OP_EQ && op <= OP_GE);

  // First read in decode, second read (top of stack) afterwards.
  always_comb begin
    st_raddr = sp_m1[SAW-1:0];
    if (state_r == S_DEC) begin
      if (op == OP_RSF) begin
        st_raddr = fp_m1[SAW-1:0];
      end else if (op == OP_PUSHL) begin
        st_raddr = idx_u[SAW-1:0];
      end else begin
        st_raddr = sp_m2[SAW-1:0];
      end
    end
  end

  smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  smx_ram #(.WIDTH(32), .DEPTH(GLOBAL_DEPTH)) u_globals (
    .clk   (clk),
    .we    (g_we),
    .waddr (instr_r[GAW-1:0]),
    .wdata (b_r),
    .raddr (instr_r[GAW-1:0]),
    .rdata (g_rdata)
  );

  assign alu_req.start = (state_r == S_CAP) && is_alu;
  assign alu_req.op    = op;

  smx_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (a_r),
    .b     (st_rdata),
    .rsp   (alu_rsp)
  );

  assign wb_go = (state_r == S_WB) && (!out_valid_r || out_tready);

  // Execute: checks, next state of the machine registers and the one memory write.
  always_comb begin
    status     = ST_OK;
    npc        = pc_r + 24'd1;
    kind       = KIND_NONE;
    val        = 32'd0;
    sp_nxt     = sp_r;
    fp_nxt     = fp_r;
    retv_nxt   = retv_r;
    halted_nxt = halted_r;
    st_we      = 1'b0;
    st_waddr   = sp_r[SAW-1:0];
    st_wdata   = 32'd0;
    g_we       = 1'b0;
    if (halted_r) begin
      status = ST_HALTED;
      npc    = pc_r;
    end else begin
      unique case (op)
        OP_HALT: begin
          halted_nxt = 1'b1;
          status     = ST_HALTED;
          npc        = pc_r;
        end
        OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHR, OP_CALL: begin
          if (sp_s >= d_s) begin
            status = ST_STACK;
          end else begin
            st_we  = 1'b1;
            sp_nxt = sp_p1;
            unique case (op)
              OP_PUSHC: st_wdata = imm32;
              OP_PUSHR: st_wdata = retv_r;
              OP_CALL: begin
                st_wdata = {8'd0, npc};
                npc      = instr_r[23:0];
              end
              default:  st_wdata = rv_r;
            endcase
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
        OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
          if (sp_s < SW'(2)) begin
            status = ST_STACK;
          end else if ((op == OP_DIV || op == OP_MOD) && b_r == 32'd0) begin
            status = ST_DIVZ;
          end else begin
            st_we    = 1'b1;
            st_waddr = sp_m2[SAW-1:0];
            st_wdata = res_r;
            sp_nxt   = sp_m1;
          end
        end
        OP_WRINT, OP_WRCHR, OP_BRF, OP_BRT, OP_RET, OP_POPR: begin
          if (sp_r == '0) begin
            status = ST_STACK;
          end else begin
            sp_nxt = sp_m1;
            unique case (op)
              OP_WRINT: begin kind = KIND_INT; val = b_r; end
              OP_WRCHR: begin kind = KIND_CHR; val = b_r; end
              OP_BRF:   if (b_r == 32'd0) npc = instr_r[23:0];
              OP_BRT:   if (b_r == 32'd1) npc = instr_r[23:0];
              OP_RET:   npc = b_r[23:0];
              default:  retv_nxt = b_r;
            endcase
          end
        end
        OP_PUSHG: begin
          if (imm_s < 0 || imm_s >= giu_s || imm_s >= gd_s) begin
            status = ST_GLOBAL;
          end else if (sp_s >= d_s) begin
            status = ST_STACK;
          end else begin
            st_we    = 1'b1;
            st_wdata = g_r;
            sp_nxt   = sp_p1;
          end
        end
        OP_POPG: begin
          if (imm_s < 0 || imm_s >= giu_s || imm_s >= gd_s) begin
            status = ST_GLOBAL;
          end else if (sp_r == '0) begin
            status = ST_STACK;
          end else begin
            g_we   = 1'b1;
            sp_nxt = sp_m1;
          end
        end
        OP_ASF: begin
          if (imm_s < 0 || asf_top > d_s) begin
            status = ST_STACK;
          end else begin
            st_we    = 1'b1;
            st_wdata = 32'(fp_r);
            fp_nxt   = sp_p1;
            sp_nxt   = asf_top[SPW-1:0];
          end
        end
        OP_RSF: begin
          if (fp_r == '0 || fp_s > d_s || a_r > 32'(STACK_DEPTH)) begin
            status = ST_STACK;
          end else begin
            sp_nxt = fp_m1;
            fp_nxt = a_r[SPW-1:0];
          end
        end
        OP_PUSHL: begin
          if (idx_s < 0 || idx_s >= sp_s || sp_s >= d_s) begin
            status = ST_STACK;
          end else begin
            st_we    = 1'b1;
            st_wdata = a_r;
            sp_nxt   = sp_p1;
          end
        end
        OP_POPL: begin
          if (sp_r == '0 || idx_s < 0 || idx_s >= sp_s - SW'(1)) begin
            status = ST_STACK;
          end else begin
            st_we    = 1'b1;
            st_waddr = idx_u[SAW-1:0];
            st_wdata = b_r;
            sp_nxt   = sp_m1;
          end
        end
        OP_JMP: npc = instr_r[23:0];
        OP_DROP: begin
          if (imm_s > sp_s) begin
            status = ST_STACK;
          end else if (imm_s >= 0) begin
            sp_nxt = sp_r - imm_s[SPW-1:0];
          end
        end
        OP_DUP: begin
          if (sp_r == '0 || sp_s >= d_s) begin
            status = ST_STACK;
          end else begin
            st_we    = 1'b1;
            st_wdata = b_r;
            sp_nxt   = sp_p1;
          end
        end
        default: ;
      endcase
      if (status == ST_DIVZ || status == ST_STACK || status == ST_GLOBAL) begin
        npc    = pc_r;
        kind   = KIND_NONE;
        val    = 32'd0;
        sp_nxt = sp_r;
        fp_nxt = fp_r;
        retv_nxt = retv_r;
        st_we  = 1'b0;
        g_we   = 1'b0;
      end
    end
    if (!wb_go) begin
      st_we = 1'b0;
      g_we  = 1'b0;
    end
  end

  assign pc_nxt = npc;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_DEC;
      S_DEC:   state_nxt = S_RDB;
      S_RDB:   state_nxt = S_CAP;
      S_CAP:   state_nxt = is_alu ? S_ALU : S_WB;
      S_ALU:   if (alu_rsp.done) state_nxt = S_WB;
      S_WB:    if (wb_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      fp_r        <= '0;
      pc_r        <= 24'd0;
      retv_r      <= 32'd0;
      halted_r    <= 1'b0;
      giu_r       <= GIU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        giu_r <= cfg_wdata;
      end
      if (wb_go) begin
        sp_r        <= sp_nxt;
        fp_r        <= fp_nxt;
        pc_r        <= pc_nxt;
        retv_r      <= retv_nxt;
        halted_r    <= halted_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == S_IDLE && in_tvalid) begin
      instr_r <= in_tdata[31:0];
      rv_r    <= in_tdata[63:32];
    end
    if (state_r == S_RDB) begin
      a_r <= st_rdata;
    end
    if (state_r == S_CAP) begin
      b_r <= st_rdata;
      g_r <= g_rdata;
    end
    if (state_r == S_ALU && alu_rsp.done) begin
      res_r <= alu_rsp.result;
    end
    if (wb_go) begin
      out_data_r <= {5'd0, status, val, npc};
      out_user_r <= kind;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The stack pointer never passes the stack depth.
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // Once halted, the machine stays halted with a frozen pc.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r && $stable(pc_r))
    else $error("halt state left or pc moved while halted");

  // An accepted request always moves into decode.
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DEC))
    else $error("accepted request did not enter decode");

  // Machine registers only change at write back.
  a_sp_wb_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WB) |=> $stable(sp_r))
    else $error("stack pointer changed outside write back");

endmodule
`default_nettype wire

// ===== tb/sv/stack_machine_execute_unit_test.sv =====
// Self-checking testbench of the stack machine execute unit with its own instruction predictor.
module stack_machine_execute_unit_test;
  import smx_pkg::*;

  // The predictor mirrors the unit at its default sizes.
  localparam int STK = STACK_DEPTH_DEF;
  localparam int GLB = GLOBAL_DEPTH_DEF;
  // Cycles without any request moving before the run is declared stuck. The worst case is
  // a divide behind a long receiver hold-off, so this is far above anything a good run needs.
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 90;

  typedef struct packed {
    logic [23:0] pc;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [2:0]  status;
  } exec_result_t;

  typedef struct {
    logic [31:0] word;
    logic [31:0] rv;
  } instr_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] instr_word, [63:32] read_value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [23:0] next_pc, [55:24] out_value, [58:56] status
  logic [1:0]  out_tuser;       // [1:0] out_kind
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;  // [8:0] globals_in_use

  stack_machine_execute_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Requests still to be offered, and the results the predictor expects for requests
  // already queued, oldest first.
  instr_req_t   pending_instrs[$];
  exec_result_t predicted_results[$];

  // Predicted machine state. The written flags keep the stimulus from ever reading a
  // stack or global entry that holds nothing defined yet.
  logic [31:0] stk [STK];
  bit          stk_set [STK];
  logic [31:0] glb [GLB];
  bit          glb_set [GLB];
  int          sp = 0;
  int          fp = 0;
  logic [23:0] pc_q = '0;
  logic [31:0] rval = '0;
  bit          halted = 1'b0;
  int          giu = 256;

  int send_idle = 11;
  int recv_idle = 61;
  bit hold_out = 1'b0;
  int accepted_in = 0;
  int errors = 0;
  int quiet = 0;
  instr_req_t   drive_req;
  exec_result_t seen;

  // Two-operand arithmetic and the signed comparisons; results wrap to 32 bits.
  function automatic logic [31:0] combine(logic [7:0] op, logic [31:0] x, logic [31:0] y);
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] q;
    a = x;
    b = y;
    case (op)
      OP_ADD: return x + y;
      OP_SUB: return x - y;
      OP_MUL: return x * y;
      OP_DIV: begin
        // The most negative value over minus one wraps back onto itself.
        if (y == 32'hFFFF_FFFF) return -x;
        q = a / b;
        return q;
      end
      OP_MOD: begin
        if (y == 32'hFFFF_FFFF) return 32'd0;
        q = a % b;
        return q;
      end
      OP_EQ: return {31'd0, a == b};
      OP_NE: return {31'd0, a != b};
      OP_LT: return {31'd0, a < b};
      OP_LE: return {31'd0, a <= b};
      OP_GT: return {31'd0, a > b};
      default: return {31'd0, a >= b};
    endcase
  endfunction

  function automatic bit global_ok(int imm);
    return imm >= 0 && imm < giu && imm < GLB;
  endfunction

  // True when the instruction would get past its fault checks and read an entry that was
  // never written. Conservative: a possible read is enough to reject it.
  function automatic bit reads_unwritten(logic [31:0] word);
    logic [7:0] op;
    int imm;
    int idx;
    op = word[31:24];
    imm = int'($signed(word[23:0]));
    idx = fp + imm;
    if (halted) return 1'b0;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE:
        return sp >= 2 && (!stk_set[sp-1] || !stk_set[sp-2]);
      OP_WRINT, OP_WRCHR, OP_BRF, OP_BRT, OP_RET, OP_POPR:
        return sp >= 1 && !stk_set[sp-1];
      OP_DUP:   return sp >= 1 && sp < STK && !stk_set[sp-1];
      OP_PUSHG: return global_ok(imm) && sp < STK && !glb_set[imm];
      OP_POPG:  return global_ok(imm) && sp >= 1 && !stk_set[sp-1];
      OP_RSF:   return fp != 0 && fp <= STK && !stk_set[fp-1];
      OP_PUSHL: return idx >= 0 && idx < sp && sp < STK && !stk_set[idx];
      OP_POPL:  return sp != 0 && idx >= 0 && idx < sp - 1 && !stk_set[sp-1];
      default:  return 1'b0;
    endcase
  endfunction

  // Executes one instruction on the predicted state and returns its result.
  function automatic exec_result_t execute_instr(logic [31:0] word, logic [31:0] rv);
    logic [7:0]  op;
    int          imm;
    int          idx;
    logic [23:0] npc;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] v;
    logic [2:0]  st;
    exec_result_t r;
    op = word[31:24];
    imm = int'($signed(word[23:0]));
    npc = pc_q + 24'd1;
    st = ST_OK;
    r.kind = KIND_NONE;
    r.value = '0;
    if (halted) begin
      st = ST_HALTED;
      npc = pc_q;
    end else begin
      case (op)
        OP_HALT: begin
          halted = 1'b1;
          st = ST_HALTED;
          npc = pc_q;
        end
        OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHR, OP_CALL: begin
          if (sp >= STK) st = ST_STACK;
          else begin
            if (op == OP_PUSHC) stk[sp] = 32'(imm);
            else if (op == OP_PUSHR) stk[sp] = rval;
            else if (op == OP_CALL) stk[sp] = {8'd0, npc};
            else stk[sp] = rv;
            stk_set[sp] = 1'b1;
            sp++;
            if (op == OP_CALL) npc = word[23:0];
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
          if (sp < 2) st = ST_STACK;
          else begin
            x = stk[sp-2];
            y = stk[sp-1];
            if ((op == OP_DIV || op == OP_MOD) && y == 32'd0) st = ST_DIVZ;
            else begin
              stk[sp-2] = combine(op, x, y);
              sp--;
            end
          end
        end
        OP_WRINT, OP_WRCHR: begin
          if (sp < 1) st = ST_STACK;
          else begin
            r.value = stk[sp-1];
            r.kind = (op == OP_WRINT) ? KIND_INT : KIND_CHR;
            sp--;
          end
        end
        OP_PUSHG: begin
          // The index check wins over the stack check.
          if (!global_ok(imm)) st = ST_GLOBAL;
          else if (sp >= STK) st = ST_STACK;
          else begin
            stk[sp] = glb[imm];
            stk_set[sp] = 1'b1;
            sp++;
          end
        end
        OP_POPG: begin
          if (!global_ok(imm)) st = ST_GLOBAL;
          else if (sp < 1) st = ST_STACK;
          else begin
            glb[imm] = stk[sp-1];
            glb_set[imm] = 1'b1;
            sp--;
          end
        end
        OP_ASF: begin
          if (imm < 0 || sp + 1 + imm > STK) st = ST_STACK;
          else begin
            stk[sp] = 32'(fp);
            stk_set[sp] = 1'b1;
            fp = sp + 1;
            sp = sp + 1 + imm;
          end
        end
        OP_RSF: begin
          if (fp == 0 || fp > STK) st = ST_STACK;
          else begin
            v = stk[fp-1];
            if (v > STK) st = ST_STACK;
            else begin
              sp = fp - 1;
              fp = int'(v);
            end
          end
        end
        OP_PUSHL: begin
          idx = fp + imm;
          if (idx < 0 || idx >= sp || sp >= STK) st = ST_STACK;
          else begin
            stk[sp] = stk[idx];
            stk_set[sp] = 1'b1;
            sp++;
          end
        end
        OP_POPL: begin
          idx = fp + imm;
          if (sp == 0 || idx < 0 || idx >= sp - 1) st = ST_STACK;
          else begin
            stk[idx] = stk[sp-1];
            stk_set[idx] = 1'b1;
            sp--;
          end
        end
        OP_JMP: npc = word[23:0];
        OP_BRF, OP_BRT: begin
          if (sp < 1) st = ST_STACK;
          else begin
            v = stk[sp-1];
            if ((op == OP_BRF && v == 32'd0) || (op == OP_BRT && v == 32'd1)) npc = word[23:0];
            sp--;
          end
        end
        OP_RET: begin
          if (sp < 1) st = ST_STACK;
          else begin
            npc = stk[sp-1][23:0];
            sp--;
          end
        end
        OP_DROP: begin
          // A negative count is a no-op.
          if (imm >= 0) begin
            if (imm > sp) st = ST_STACK;
            else sp = sp - imm;
          end
        end
        OP_POPR: begin
          if (sp < 1) st = ST_STACK;
          else begin
            rval = stk[sp-1];
            sp--;
          end
        end
        OP_DUP: begin
          if (sp < 1 || sp + 1 > STK) st = ST_STACK;
          else begin
            stk[sp] = stk[sp-1];
            stk_set[sp] = 1'b1;
            sp++;
          end
        end
        default: ;
      endcase
      // A fault leaves the pc where it was and suppresses any write output.
      if (st >= ST_DIVZ) begin
        npc = pc_q;
        r.kind = KIND_NONE;
        r.value = '0;
      end
      pc_q = npc;
    end
    r.pc = npc;
    r.status = st;
    return r;
  endfunction

  // Random instruction with an immediate shaped per opcode so that most of them do real
  // work on a small stack, and some are out-of-range noise.
  function automatic logic [31:0] pick_word();
    int op;
    int imm;
    bit wild;
    wild = ($urandom_range(9) == 0);
    if ($urandom_range(99) < 4) op = $urandom_range(255, 32);
    else op = $urandom_range(31, 1);
    imm = $urandom;
    case (8'(op))
      OP_PUSHG, OP_POPG: if (!wild) begin
        imm = ($urandom_range(3) == 0) ? $urandom_range(260, 0) : $urandom_range(3, 0);
      end
      OP_ASF: if (!wild) imm = $urandom_range(3, 0);
      OP_DROP: if (!wild) imm = $urandom_range(4, 0) - 1;
      OP_PUSHL, OP_POPL: if (!wild) imm = $urandom_range(8, 0) - 4;
      default: ;
    endcase
    return {8'(op), imm[23:0]};
  endfunction

  task automatic queue_instr(logic [31:0] word, logic [31:0] rv);
    instr_req_t req;
    req.word = word;
    req.rv = rv;
    pending_instrs.push_back(req);
    predicted_results.push_back(execute_instr(word, rv));
  endtask

  // Directed instruction; one that would read undefined storage is skipped.
  task automatic directed(logic [7:0] op, int imm, logic [31:0] rv);
    logic [31:0] w;
    w = {op, imm[23:0]};
    if (!reads_unwritten(w)) queue_instr(w, rv);
  endtask

  task automatic random_instrs(int n);
    logic [31:0] w;
    repeat (n) begin
      do w = pick_word(); while (reads_unwritten(w));
      queue_instr(w, $urandom);
    end
  endtask

  // Waits until every queued request has come back as a result.
  task automatic wait_drained();
    while (pending_instrs.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_globals_in_use(int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 9'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    giu = value;
  endtask

  task automatic set_idle(int s, int r);
    @(posedge clk);
    send_idle <= s;
    recv_idle <= r;
  endtask

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Driver: a request stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) accepted_in++;
      if (!in_tvalid || in_tready) begin
        if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle) begin
          drive_req = pending_instrs.pop_front();
          in_tdata <= {drive_req.rv, drive_req.word};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_out && ($urandom_range(99) >= recv_idle);
      if (out_tvalid && out_tready) begin
        if (predicted_results.size() == 0) begin
          report("result arrived with nothing predicted");
        end else begin
          seen = predicted_results.pop_front();
          if (out_tdata[23:0] !== seen.pc)
            report($sformatf("next_pc %h, predicted %h", out_tdata[23:0], seen.pc));
          if (out_tuser !== seen.kind)
            report($sformatf("out_kind %0d, predicted %0d", out_tuser, seen.kind));
          if (out_tdata[55:24] !== seen.value)
            report($sformatf("out_value %h, predicted %h", out_tdata[55:24], seen.value));
          if (out_tdata[58:56] !== seen.status)
            report($sformatf("status %0d, predicted %0d", out_tdata[58:56], seen.status));
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("stack_machine_execute_unit_test NOT OK");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the unit backs up.
  initial begin
    while (accepted_in < 60) @(posedge clk);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the reset value of 256 usable globals.
    directed(OP_ADD, 0, 0);                  // underflow on an empty stack
    directed(OP_RDINT, 0, 32'h8000_0000);
    directed(OP_RDINT, 0, 32'hFFFF_FFFF);
    directed(OP_DIV, 0, 0);                  // most negative over minus one
    directed(OP_RDINT, 0, 32'h8000_0000);
    directed(OP_RDINT, 0, 32'hFFFF_FFFF);
    directed(OP_MOD, 0, 0);                  // remainder zero for the same pair
    directed(OP_PUSHC, 0, 0);
    directed(OP_DIV, 0, 0);                  // zero divisor
    directed(OP_DROP, 1, 0);
    directed(OP_WRINT, 0, 0);
    directed(OP_WRCHR, 0, 0);
    directed(OP_WRINT, 0, 0);                // pop on empty
    directed(OP_RDCHR, 0, 32'h7FFF_FFFF);
    directed(OP_PUSHC, 24'h7F_FFFF, 0);
    directed(OP_PUSHC, -24'sh80_0000, 0);
    directed(OP_POPG, 300, 0);               // index beyond the global store
    directed(OP_POPG, 255, 0);
    directed(OP_PUSHG, 255, 0);
    directed(OP_PUSHG, 256, 0);
    directed(OP_DROP, -1, 0);                // negative count drops nothing
    directed(OP_DROP, 50, 0);                // more than the stack holds
    directed(OP_RSF, 0, 0);                  // no frame to restore
    directed(OP_ASF, -1, 0);
    directed(OP_ASF, 1020, 0);               // fills the stack to the brim
    directed(OP_PUSHC, 1, 0);                // push beyond the top
    directed(OP_RSF, 0, 0);
    directed(OP_JMP, 24'hFF_FFFF, 0);
    directed(8'hFF, 24'hFF_FFFF, 0);         // unknown opcode, pc wraps to zero
    wait_drained();

    // Random phases through several register settings and idle patterns.
    write_globals_in_use(0);
    random_instrs(PHASE_ITEMS);
    wait_drained();
    write_globals_in_use(1);
    random_instrs(PHASE_ITEMS);
    wait_drained();
    set_idle(61, 11);
    write_globals_in_use(256);
    random_instrs(PHASE_ITEMS);
    wait_drained();
    write_globals_in_use($urandom_range(255, 2));
    random_instrs(PHASE_ITEMS);
    wait_drained();
    set_idle(0, 0);
    write_globals_in_use(255);
    random_instrs(PHASE_ITEMS);
    // Halt comes last: the machine then stays halted, so a few more requests check that.
    queue_instr({OP_HALT, 24'h00_0000}, 0);
    random_instrs(3);
    wait_drained();
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("stack_machine_execute_unit_test OK");
    end else begin
      $display("stack_machine_execute_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/smx_pkg.sv
src/smx_ram.sv
src/smx_alu.sv
src/stack_machine_execute_unit.sv
tb/sv/stack_machine_execute_unit_test.sv
